// ===== sv/rcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpa_pkg: shared types and constants
// Register codes, widths, fixed-point constants and the controller command.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpa_pkg;

  localparam int WIDTH_W = 12;  // pulse width, us
  localparam int UNIT_W  = 16;  // Q0.16 normalized value
  localparam int ANGLE_W = 14;  // Q0.13 (sign + 13 fraction bits) roll/pitch
  localparam int YAW_W   = 16;  // Q2.13 heading out
  localparam int HDG_W   = 28;  // Q2.24 heading state
  localparam int INC_W   = 21;  // per-item heading increment
  localparam int MUL_A_W = 18;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int OFFSET_W = 12;
  localparam int SPAN_W   = 24;
  localparam int GATE_W   = 16;
  localparam int GAIN_W   = 20;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 12'd1011;
  localparam logic [SPAN_W-1:0]   SPAN_RST   = 24'd4299262;
  localparam logic [GATE_W-1:0]   GATE_RST   = 16'd13107;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 20'd263538;

  // pi/3 in Q0.16, pi in Q2.24
  localparam logic signed [MUL_B_W-1:0] PI_THIRD_Q16 = 25'sd68629;
  localparam logic signed [HDG_W-1:0]   PI_Q24       = 28'sd52707179;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_OFFSET = 2'd0,
    REG_SPAN_RECIP   = 2'd1,
    REG_THR_GATE     = 2'd2,
    REG_YAW_GAIN     = 2'd3
  } cfg_reg_t;

  // Multiply schedule, issued in this order by the controller.
  typedef enum logic [2:0] {
    OP_NORM_Y = 3'd0,
    OP_NORM_T = 3'd1,
    OP_NORM_R = 3'd2,
    OP_NORM_P = 3'd3,
    OP_YAW    = 3'd4,
    OP_ANG_R  = 3'd5,
    OP_ANG_P  = 3'd6
  } op_t;

  typedef struct packed {
    logic load;       // capture input request
    logic mul_en;     // issue a multiply
    op_t  op;
    logic hdg_upd;    // apply increment to heading
    logic yout_calc;  // round heading to Q2.13
    logic out_load;   // move results into output register
  } rcpa_cmd_t;

endpackage

`default_nettype wire

// ===== sv/rcpa_if.sv =====
// ----------------------------------------------------------------------------
// rcpa_in_if / rcpa_out_if: request channels
// Valid/ready channels carrying pulse widths in and attitude commands out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpa_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] roll_width;
  logic [11:0] pitch_width;
  logic [11:0] throttle_width;
  logic [11:0] yaw_width;
  logic        lock_engaged;

  modport source (output valid, roll_width, pitch_width, throttle_width, yaw_width,
                  lock_engaged, input ready);
  modport sink   (input valid, roll_width, pitch_width, throttle_width, yaw_width,
                  lock_engaged, output ready);
endinterface

interface rcpa_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] throttle_cmd;
  logic signed [13:0] pitch_cmd;
  logic signed [13:0] roll_cmd;
  logic signed [15:0] yaw_cmd;

  modport source (output valid, throttle_cmd, pitch_cmd, roll_cmd, yaw_cmd,
                  input ready);
  modport sink   (input valid, throttle_cmd, pitch_cmd, roll_cmd, yaw_cmd,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/rc_pulse_to_attitude_command.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_to_attitude_command: receiver pulses to attitude commands
// Requests are handled one at a time, through seven passes of the single shared
// multiplier plus accept, drain and handoff. Input is taken again while a result
// waits in the output register.
// Reset (sync, active low) restores register defaults and zeroes the heading.
// ----------------------------------------------------------------------------
`default_nettype none

// Flow per request:
//   accept       - widths and lock captured
//   7 mul steps  - normalize yaw, throttle, roll, pitch; yaw rate; roll, pitch
//                  angles. Each product is registered, then written back.
//   heading      - integrate (gated by lock and throttle), clamp to +-pi
//   drain        - last angle lands, heading rounded to Q2.13
//   done         - results move to the output register when it is free
module rc_pulse_to_attitude_command
  import rcpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  rcpa_in_if.sink                    in_ch,
  rcpa_out_if.source                 out_ch
);

  rcpa_cmd_t cmd;

  rcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  rcpa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .roll_width     (in_ch.roll_width),
    .pitch_width    (in_ch.pitch_width),
    .throttle_width (in_ch.throttle_width),
    .yaw_width      (in_ch.yaw_width),
    .lock_engaged   (in_ch.lock_engaged),
    .throttle_cmd   (out_ch.throttle_cmd),
    .pitch_cmd      (out_ch.pitch_cmd),
    .roll_cmd       (out_ch.roll_cmd),
    .yaw_cmd        (out_ch.yaw_cmd)
  );

endmodule

`default_nettype wire

// ===== sv/rcpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcpa_ctrl: sequencer
// Steps the shared multiplier schedule and owns the request handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_ctrl
  import rcpa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rcpa_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.op        = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = OP_NORM_Y;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.mul_en  = 1'b1;
        // yaw increment: product registered, then written back; applied at OP_ANG_P
        cmd.hdg_upd = (step_r == OP_ANG_P);
        if (step_r == OP_ANG_P) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = op_t'(step_r + 3'd1);
        end
      end
      S_DRAIN: begin
        cmd.yout_calc = 1'b1;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (state_r == S_DRAIN) begin
      state_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= OP_NORM_Y;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rcpa_dp.sv =====
// ----------------------------------------------------------------------------
// rcpa_dp: datapath
// Config registers, one shared 18x25 multiplier, heading integrator, outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpa_dp
  import rcpa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire rcpa_cmd_t              cmd,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [WIDTH_W-1:0]     roll_width,
  input  wire logic [WIDTH_W-1:0]     pitch_width,
  input  wire logic [WIDTH_W-1:0]     throttle_width,
  input  wire logic [WIDTH_W-1:0]     yaw_width,
  input  wire logic                   lock_engaged,
  output logic [UNIT_W-1:0]           throttle_cmd,
  output logic signed [ANGLE_W-1:0]   pitch_cmd,
  output logic signed [ANGLE_W-1:0]   roll_cmd,
  output logic signed [YAW_W-1:0]     yaw_cmd
);

  // config
  logic [OFFSET_W-1:0] offset_r;
  logic [SPAN_W-1:0]   span_r;
  logic [GATE_W-1:0]   gate_r;
  logic [GAIN_W-1:0]   gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      span_r   <= SPAN_RST;
      gate_r   <= GATE_RST;
      gain_r   <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PULSE_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
        REG_SPAN_RECIP:   span_r   <= cfg_wdata[SPAN_W-1:0];
        REG_THR_GATE:     gate_r   <= cfg_wdata[GATE_W-1:0];
        REG_YAW_GAIN:     gain_r   <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [WIDTH_W-1:0] w_roll_r, w_pitch_r, w_thr_r, w_yaw_r;
  logic               lock_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_roll_r  <= roll_width;
      w_pitch_r <= pitch_width;
      w_thr_r   <= throttle_width;
      w_yaw_r   <= yaw_width;
      lock_r    <= lock_engaged;
    end
  end

  // intermediate results
  logic [UNIT_W-1:0]         u_roll_r, u_pitch_r, u_thr_r, u_yaw_r;
  logic signed [ANGLE_W-1:0] ang_roll_r, ang_pitch_r;
  logic signed [INC_W-1:0]   inc_r;
  logic signed [HDG_W-1:0]   hdg_r;
  logic signed [YAW_W-1:0]   yout_r;

  // operand select
  logic [WIDTH_W-1:0]       w_sel;
  logic [WIDTH_W:0]         diff;
  logic [UNIT_W-1:0]        u_sel;
  logic signed [UNIT_W-1:0] ctr;   // u - 0.5: flip the MSB
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    w_sel = w_yaw_r;
    u_sel = u_yaw_r;
    unique case (cmd.op)
      OP_NORM_Y: w_sel = w_yaw_r;
      OP_NORM_T: w_sel = w_thr_r;
      OP_NORM_R: w_sel = w_roll_r;
      OP_NORM_P: w_sel = w_pitch_r;
      OP_YAW:    u_sel = u_yaw_r;
      OP_ANG_R:  u_sel = u_roll_r;
      OP_ANG_P:  u_sel = u_pitch_r;
      default: ;
    endcase
    diff = {1'b0, w_sel} - {1'b0, offset_r};
    ctr  = $signed({~u_sel[UNIT_W-1], u_sel[UNIT_W-2:0]});

    unique case (cmd.op)
      OP_NORM_Y, OP_NORM_T, OP_NORM_R, OP_NORM_P: begin
        // width at or below offset normalizes to zero
        mul_a = diff[WIDTH_W] ? '0 : $signed(MUL_A_W'({1'b0, diff[WIDTH_W-1:0]}));
        mul_b = $signed(MUL_B_W'({1'b0, span_r}));
      end
      OP_YAW: begin
        mul_a = MUL_A_W'(ctr);
        mul_b = $signed(MUL_B_W'({1'b0, gain_r}));
      end
      default: begin
        mul_a = MUL_A_W'(ctr);
        mul_b = PI_THIRD_Q16;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  logic signed [PROD_W-1:0] p_r;
  op_t                      pop_r;
  logic                     pvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_r   <= prod;
      pop_r <= cmd.op;
    end
  end

  // writeback of the registered product
  logic [UNIT_W-1:0]        u_wb;
  logic signed [PROD_W-1:0] p_ang, p_inc;

  assign u_wb  = (p_r[PROD_W-1:2*UNIT_W] != '0) ? '1 : p_r[2*UNIT_W-1:UNIT_W];
  assign p_ang = p_r + PROD_W'(1 << 18);
  assign p_inc = p_r + PROD_W'(1 << 15);

  always_ff @(posedge clk) begin
    if (pvalid_r) begin
      unique case (pop_r)
        OP_NORM_Y: u_yaw_r     <= u_wb;
        OP_NORM_T: u_thr_r     <= u_wb;
        OP_NORM_R: u_roll_r    <= u_wb;
        OP_NORM_P: u_pitch_r   <= u_wb;
        OP_YAW:    inc_r       <= p_inc[INC_W+15:16];
        OP_ANG_R:  ang_roll_r  <= p_ang[ANGLE_W+18:19];
        OP_ANG_P:  ang_pitch_r <= p_ang[ANGLE_W+18:19];
        default: ;
      endcase
    end
  end

  // heading integrator with clamp to +-pi
  logic signed [HDG_W:0]   h_sum;
  logic signed [HDG_W-1:0] h_clamped;
  logic                    hdg_en;

  assign h_sum  = (HDG_W+1)'(hdg_r) + (HDG_W+1)'(inc_r);
  assign hdg_en = cmd.hdg_upd && !lock_r && (u_thr_r > gate_r);

  always_comb begin
    if (h_sum > (HDG_W+1)'(PI_Q24)) begin
      h_clamped = PI_Q24;
    end else if (h_sum < -(HDG_W+1)'(PI_Q24)) begin
      h_clamped = -PI_Q24;
    end else begin
      h_clamped = h_sum[HDG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdg_r <= '0;
    end else if (hdg_en) begin
      hdg_r <= h_clamped;
    end
  end

  logic signed [HDG_W:0] h_round;
  assign h_round = (HDG_W+1)'(hdg_r) + (HDG_W+1)'(1 << 10);

  always_ff @(posedge clk) begin
    if (cmd.yout_calc) begin
      yout_r <= h_round[YAW_W+10:11];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      throttle_cmd <= u_thr_r;
      pitch_cmd    <= ang_pitch_r;
      roll_cmd     <= ang_roll_r;
      yaw_cmd      <= yout_r;
    end
  end

endmodule

`default_nettype wire
